### sv/cfla_pkg.sv
// ----------------------------------------------------------------------------
// cfla_pkg
// Shared types and codes of the chunked free-list allocator with sweep.
// ----------------------------------------------------------------------------
package cfla_pkg;

  // Pool geometry; the field widths below are sized for this pool.
  localparam int OBJECTS_PER_CHUNK = 16;
  localparam int CHUNK_COUNT       = 64;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_MARK  = 2'd1,
    OP_SWEEP = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_OOM = 1'b1;

  typedef struct packed {
    logic [1:0] op;
    logic [9:0] target_object;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [9:0]  granted_object;
    logic [10:0] free_count;
  } rsp_t;

endpackage

### sv/cfla_ram.sv
// ----------------------------------------------------------------------------
// cfla_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module cfla_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

### sv/chunked_free_list_allocator_sweep.sv
// ----------------------------------------------------------------------------
// chunked_free_list_allocator_sweep
// Object allocator over a chunked pool: allocate, mark, and a full sweep.
// ----------------------------------------------------------------------------
// Flow, input transfer to result valid: mark, op 3 and out of memory go straight to
//   the result; allocate from the list reads the head's link; allocate that opens a
//   chunk links its objects first; sweep reads every chunk entry and each in-use mark.
// Throughput: one operation at a time; the next transfer is taken the cycle after
//   the result leaves.
// Reset: state, list and count registers reset at once, then a pass clears marks and chunk table.
module chunked_free_list_allocator_sweep (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cfla_pkg::req_t    in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cfla_pkg::rsp_t    out_data_o
);
  import cfla_pkg::*;

  localparam int Total = OBJECTS_PER_CHUNK * CHUNK_COUNT;
  localparam int OW    = $clog2(Total + 1);        // object index incl. null
  localparam int OA    = (Total > 1) ? $clog2(Total) : 1;
  localparam int CW    = $clog2(CHUNK_COUNT + 1);
  localparam int CA    = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
  localparam int IW    = (OBJECTS_PER_CHUNK > 1) ? $clog2(OBJECTS_PER_CHUNK) : 1;
  localparam logic [OW-1:0] ObjNull   = OW'(Total);
  localparam logic [CW-1:0] ChunkNull = CW'(CHUNK_COUNT);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ARD   = 4'd1;  // link read issued
  localparam logic [3:0] S_AFIN  = 4'd2;  // link data available
  localparam logic [3:0] S_FILL  = 4'd3;  // link a fresh chunk
  localparam logic [3:0] S_SCH   = 4'd4;  // sweep: next chunk, read its entry
  localparam logic [3:0] S_SRD   = 4'd5;  // sweep: mark read issued
  localparam logic [3:0] S_SWR   = 4'd6;  // sweep: act on mark
  localparam logic [3:0] S_SEND  = 4'd7;  // sweep: close chunk
  localparam logic [3:0] S_OUT   = 4'd8;
  localparam logic [3:0] S_CLR   = 4'd9;  // clearing pass after reset
  localparam logic [3:0] S_SCK   = 4'd10; // sweep: chunk entry available

  logic [3:0]  state_q, state_d;
  logic [OW-1:0] head_q, head_d, lhead_q, lhead_d;
  logic [OW-1:0] len_q, len_d, llen_q, llen_d, space_q, space_d;
  logic [OW-1:0] clr_q, clr_d;
  logic [CW-1:0] fch_q, fch_d, cur_q, cur_d;   // cur: chunk index
  logic [IW-1:0] idx_q, idx_d;
  logic any_q, any_d;
  rsp_t rsp_q, rsp_d;

  // chunk table entry: {in use, next free chunk}
  logic c_we;
  logic [CA-1:0] c_addr;
  logic [CW:0] c_wdata, c_rdata;

  logic m_we;
  logic [OA-1:0] m_addr;
  logic m_wdata;
  logic m_rdata;

  logic l_we;
  logic [OA-1:0] l_addr;
  logic [OW-1:0] l_wdata, l_rdata;

  logic [OW-1:0] obj_cur;
  assign obj_cur = OW'(cur_q[CA-1:0]) * OW'(OBJECTS_PER_CHUNK) + OW'(idx_q);

  cfla_ram #(.Width(1), .Depth(Total)) u_mark (
    .clk_i, .we_i(m_we), .addr_i(m_addr), .wdata_i(m_wdata), .rdata_o(m_rdata)
  );
  cfla_ram #(.Width(OW), .Depth(Total)) u_link (
    .clk_i, .we_i(l_we), .addr_i(l_addr), .wdata_i(l_wdata), .rdata_o(l_rdata)
  );
  cfla_ram #(.Width(CW + 1), .Depth(CHUNK_COUNT)) u_chunk (
    .clk_i, .we_i(c_we), .addr_i(c_addr), .wdata_i(c_wdata), .rdata_o(c_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = rsp_q;

  always_comb begin
    state_d = state_q; head_d = head_q; lhead_d = lhead_q;
    len_d = len_q; llen_d = llen_q; space_d = space_q; clr_d = clr_q;
    fch_d = fch_q; cur_d = cur_q; idx_d = idx_q; any_d = any_q;
    rsp_d = rsp_q;
    m_we = 1'b0; m_addr = obj_cur[OA-1:0]; m_wdata = 1'b0;
    l_we = 1'b0; l_addr = obj_cur[OA-1:0]; l_wdata = head_q;
    c_we = 1'b0; c_addr = cur_q[CA-1:0]; c_wdata = {1'b0, fch_q};
    case (state_q)
      S_CLR: begin
        // zero one mark per cycle; rebuild the ascending chunk chain alongside
        m_we = 1'b1; m_addr = clr_q[OA-1:0]; m_wdata = 1'b0;
        if (clr_q < OW'(CHUNK_COUNT)) begin
          c_we = 1'b1; c_addr = clr_q[CA-1:0];
          c_wdata = {1'b0, CW'(clr_q + 1'b1)};
        end
        if (clr_q == OW'(Total - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          rsp_d = '{status: STATUS_OK, granted_object: '0, free_count: 11'(space_q)};
          state_d = S_OUT;
          case (op_e'(in_data_i.op))
            OP_ALLOC: begin
              if (space_q == '0) begin
                rsp_d = '{status: STATUS_OOM, granted_object: '0, free_count: '0};
              end else if (len_q == '0) begin
                if (fch_q >= ChunkNull) begin
                  rsp_d.status = STATUS_OOM;
                end else begin
                  // fetch the chunk entry; it stays on the read port during the fill
                  c_addr = fch_q[CA-1:0];
                  cur_d = fch_q;
                  idx_d = IW'(OBJECTS_PER_CHUNK - 1);
                  state_d = S_FILL;
                end
              end else if (head_q >= ObjNull) begin
                rsp_d.status = STATUS_OOM;
              end else begin
                state_d = S_ARD;
              end
            end
            OP_MARK: begin
              if (32'(in_data_i.target_object) < Total) begin
                m_we = 1'b1; m_addr = OA'(in_data_i.target_object);
                m_wdata = 1'b1;
              end
            end
            OP_SWEEP: begin
              head_d = ObjNull; len_d = '0; space_d = '0; fch_d = ChunkNull;
              cur_d = ChunkNull; state_d = S_SCH;
            end
            default: ;
          endcase
        end
      end
      S_FILL: begin
        // link objects from highest to lowest, each ahead of the list
        l_we = 1'b1; l_addr = obj_cur[OA-1:0]; l_wdata = head_q;
        head_d = obj_cur; len_d = len_q + 1'b1;
        if (idx_q == '0) begin
          fch_d = c_rdata[CW-1:0];
          c_we = 1'b1; c_wdata = {1'b1, c_rdata[CW-1:0]};
          state_d = S_ARD;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
      S_ARD: begin
        l_addr = head_q[OA-1:0];
        state_d = S_AFIN;
      end
      S_AFIN: begin
        rsp_d = '{status: STATUS_OK, granted_object: 10'(head_q),
                  free_count: 11'(space_q - 1'b1)};
        head_d = l_rdata; len_d = len_q - 1'b1; space_d = space_q - 1'b1;
        state_d = S_OUT;
      end
      S_SCH: begin
        if (cur_q == '0) begin
          rsp_d = '{status: STATUS_OK, granted_object: '0, free_count: 11'(space_q)};
          state_d = S_OUT;
        end else begin
          cur_d = cur_q - 1'b1;
          c_addr = CA'(cur_q - 1'b1);
          state_d = S_SCK;
        end
      end
      S_SCK: begin
        if (c_rdata[CW]) begin
          idx_d = IW'(OBJECTS_PER_CHUNK - 1);
          lhead_d = head_q; llen_d = len_q; any_d = 1'b0;
          state_d = S_SRD;
        end else begin
          // free chunk: push it back on the chunk list
          space_d = space_q + OW'(OBJECTS_PER_CHUNK);
          c_we = 1'b1; c_wdata = {1'b0, fch_q};
          fch_d = cur_q;
          state_d = S_SCH;
        end
      end
      S_SRD: begin
        m_addr = obj_cur[OA-1:0];
        state_d = S_SWR;
      end
      S_SWR: begin
        if (m_rdata) begin
          m_we = 1'b1; m_wdata = 1'b0; any_d = 1'b1;
        end else begin
          l_we = 1'b1; l_wdata = lhead_q;
          lhead_d = obj_cur; llen_d = llen_q + 1'b1; space_d = space_q + 1'b1;
        end
        if (idx_q == '0) begin
          state_d = S_SEND;
        end else begin
          idx_d = idx_q - 1'b1;
          state_d = S_SRD;
        end
      end
      S_SEND: begin
        if (any_q) begin
          head_d = lhead_q; len_d = llen_q;
        end else begin
          c_we = 1'b1; c_wdata = {1'b0, fch_q};
          fch_d = cur_q;
        end
        state_d = S_SCH;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; clr_q <= '0;
      head_q <= ObjNull; len_q <= '0; space_q <= OW'(Total);
      fch_q <= '0;
    end else begin
      state_q <= state_d; clr_q <= clr_d;
      head_q <= head_d; len_q <= len_d; space_q <= space_d;
      fch_q <= fch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lhead_q <= lhead_d; llen_q <= llen_d; cur_q <= cur_d;
    idx_q <= idx_d; any_q <= any_d; rsp_q <= rsp_d;
  end

`ifndef SYNTHESIS
  a_space_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    space_q <= OW'(Total)) else $error("free space above pool size");
  a_len_le_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (len_q <= space_q)) else $error("list longer than free");
  a_grant_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AFIN) |=> (space_q == $past(space_q) - 1'b1))
    else $error("allocate did not decrement");
  a_oom_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rsp_q.status == STATUS_OOM) |-> (rsp_q.granted_object == '0))
    else $error("grant on out of memory");
`endif
endmodule
